// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the timer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property checked on every clock edge outside reset.
`define FCLAT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// Condition in one cycle implies a consequence in the next.
`define FCLAT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);
`else
`define FCLAT_ASSERT(lbl, prop, msg)
`define FCLAT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/fclat_pkg.sv =====
// Types and constants of the four-channel LFSR audio timer.
`default_nettype none
package fclat_pkg;

    localparam int CHANNELS = 4;
    localparam int NCH_OUT  = 4;
    localparam int NREGS    = 4;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int CFG_W      = 43;
    localparam int CFG_IDX_W  = 3;
    localparam int IN_TDATA_W = 72;
    localparam int OUT_TDATA_W = 80;
    localparam int SAMPLE_W   = 8;
    localparam int FLAGS_W    = 3;
    localparam int FLAGS_LSB  = NCH_OUT * SAMPLE_W;
    localparam int NEV_LSB    = FLAGS_LSB + NCH_OUT * FLAGS_W;

    localparam logic [2:0] PRE_LINKED = 3'd7;

    // Status bit positions
    localparam int ST_BORROW_IN  = 0;
    localparam int ST_BORROW_OUT = 1;
    localparam int ST_DONE       = 2;

    // LFSR bits selected by tap switches 0..8
    localparam logic [3:0] TAP_POS [9] = '{4'd7, 4'd0, 4'd1, 4'd2, 4'd3,
                                           4'd4, 4'd5, 4'd10, 4'd11};

    typedef struct packed {
        logic [11:0]       seed;
        logic [8:0]        taps;
        logic [7:0]        backup;
        logic signed [7:0] volume;
        logic              integ;
        logic              count_en;
        logic              reload;
        logic [2:0]        prescale;
    } setup_t;

    typedef struct packed {
        logic [31:0]       down;
        logic [31:0]       mark;
        logic [11:0]       lfsr;
        logic signed [7:0] level;
        logic [2:0]        status;
    } chan_state_t;

endpackage
`default_nettype wire

// ===== hdl/fclat_chan.sv =====
// Next-state logic of one timer channel: count, reload, LFSR and level.
`default_nettype none
module fclat_chan
    import fclat_pkg::*;
(
    input  setup_t      setup,
    input  chan_state_t cur,
    input  logic [31:0] cyc,
    input  logic        prev_borrow,
    output chan_state_t nxt,
    output logic        clk_run
);

    logic              linked;
    logic              run;
    logic [3:0]        div;
    logic [31:0]       elapsed;
    logic [31:0]       tick_mask;
    logic [31:0]       dec;
    logic [31:0]       diff;
    logic [31:0]       reloaded;
    logic              fb;
    logic [11:0]       lfsr_new;
    logic signed [9:0] vol_w;
    logic signed [9:0] step;
    logic signed [9:0] acc;

    always_comb begin
        linked  = (setup.prescale == PRE_LINKED);
        run     = setup.count_en && (setup.reload || !cur.status[ST_DONE])
                  && (setup.volume != 8'sd0) && (setup.backup != 8'd0);
        clk_run = run && !linked;
        div     = 4'd4 + {1'b0, setup.prescale};

        elapsed   = cyc - cur.mark;
        tick_mask = 32'hffff_ffff << div;
        dec       = linked ? {31'd0, prev_borrow} : (elapsed >> div);
        diff      = cur.down - dec;
        reloaded  = diff + {24'd0, setup.backup} + 32'd1;

        fb = 1'b0;
        for (int i = 0; i < 9; i++) begin
            if (setup.taps[i]) begin
                fb = fb ^ cur.lfsr[TAP_POS[i]];
            end
        end
        lfsr_new = {cur.lfsr[10:0], ~fb};

        vol_w = {{2{setup.volume[7]}}, setup.volume};
        step  = lfsr_new[0] ? vol_w : -vol_w;
        acc   = {{2{cur.level[7]}}, cur.level} + step;

        nxt = cur;
        if (run) begin
            if (dec != 32'd0) begin
                // advance the mark by whole ticks only
                if (!linked) begin
                    nxt.mark = cur.mark + (elapsed & tick_mask);
                end
                nxt.down = diff;
                nxt.status[ST_BORROW_IN] = 1'b1;
                if (diff[31]) begin
                    nxt.status[ST_BORROW_OUT] = 1'b1;
                    if (setup.reload) begin
                        nxt.down = reloaded[31] ? 32'd0 : reloaded;
                    end else begin
                        nxt.status[ST_DONE] = 1'b1;
                        nxt.down = 32'd0;
                    end
                    nxt.lfsr = lfsr_new;
                    if (setup.integ) begin
                        if (acc > 10'sd127) begin
                            nxt.level = 8'sd127;
                        end else if (acc < -10'sd128) begin
                            nxt.level = -8'sd128;
                        end else begin
                            nxt.level = acc[7:0];
                        end
                    end else begin
                        nxt.level = step[7:0];
                    end
                end else begin
                    nxt.status[ST_BORROW_OUT] = 1'b0;
                end
            end else begin
                nxt.status[ST_BORROW_IN]  = 1'b0;
                nxt.status[ST_BORROW_OUT] = 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/four_channel_lfsr_audio_timer.sv =====
// Top level of the four-channel LFSR audio timer.
//
//  port group   | dir | payload
//  -------------+-----+-------------------------------------------------------
//  s_t*         | in  | tdata: cycle_count, link_borrow, next_event_in
//  m_t*         | out | tdata: sample_ch0..3, flags_ch0..3, next_event_out
//  cfg_*        | in  | index of chanK_setup, 43-bit setup word
//
// One request per cycle sustained while m_tready is high; m_tvalid rises once the request has passed stages 1 to 3.
// Stage 1 registers the request, stage 2 updates all channel state (the borrow
// ripples channel to channel in that cycle), stage 3 forms the next-event minimum.
// Reset (aresetn low, synchronous) clears setup and all channel state.
// A stall on m_tready holds the result register; the two inner stages keep
// taking requests until they fill. cfg_ready is always high.
`default_nettype none
`include "assert_macros.svh"
module four_channel_lfsr_audio_timer
    import fclat_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // [31:0] cycle_count, [32] link_borrow, [64:33] next_event_in, rest zero
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // [7:0]..[31:24] sample_ch0..3, [34:32]..[43:41] flags_ch0..3,
    // [75:44] next_event_out, rest zero
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data
);

    // Channel setup and state
    setup_t      setup_reg  [CHANNELS];
    chan_state_t state_reg  [CHANNELS];
    chan_state_t state_next [CHANNELS];
    logic [CHANNELS-1:0] clk_run;

    // Stage 1: request register
    logic        in_vld_reg;
    logic [31:0] in_cyc_reg;
    logic        in_link_reg;
    logic [31:0] in_nev_reg;

    // Stage 2: updated state snapshot
    logic              mid_vld_reg;
    logic [31:0]       mid_cyc_reg;
    logic [31:0]       mid_nev_reg;
    logic [31:0]       mid_down_reg   [CHANNELS];
    logic signed [7:0] mid_level_reg  [CHANNELS];
    logic [2:0]        mid_status_reg [CHANNELS];
    logic [CHANNELS-1:0] mid_run_reg;

    // Stage 3: result register
    logic                   out_vld_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;

    logic        adv_a;
    logic        adv_b;
    logic        cfg_hit;
    logic [3:0]  pred_div [CHANNELS];
    logic [31:0] pred     [CHANNELS];
    logic [31:0] cand     [CHANNELS];
    logic [31:0] nev_min;

    // Handshakes: stage 3 drains on m_tready, each stage moves when the next frees
    assign adv_b     = mid_vld_reg && (!out_vld_reg || m_tready);
    assign adv_a     = in_vld_reg && (!mid_vld_reg || adv_b);
    assign s_tready  = !in_vld_reg || adv_a;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;
    // drop writes beyond the register list
    assign cfg_hit   = cfg_valid && (int'(cfg_index) < NREGS)
                       && (int'(cfg_index) < CHANNELS);

    // Per-channel update; borrow-out of a channel feeds the next one
    for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
        logic prev_borrow;
        if (c == 0) begin : g_first
            assign prev_borrow = in_link_reg;
        end else begin : g_link
            assign prev_borrow = state_next[c-1].status[ST_BORROW_OUT];
        end
        fclat_chan u_chan (
            .setup       (setup_reg[c]),
            .cur         (state_reg[c]),
            .cyc         (in_cyc_reg),
            .prev_borrow (prev_borrow),
            .nxt         (state_next[c]),
            .clk_run     (clk_run[c])
        );
    end

    // Control and channel state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            mid_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                setup_reg[c] <= '0;
                state_reg[c] <= '0;
            end
        end else begin
            if (s_tvalid && s_tready) begin
                in_vld_reg <= 1'b1;
            end else if (adv_a) begin
                in_vld_reg <= 1'b0;
            end
            if (adv_a) begin
                mid_vld_reg <= 1'b1;
            end else if (adv_b) begin
                mid_vld_reg <= 1'b0;
            end
            if (adv_b) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
            if (adv_a) begin
                for (int c = 0; c < CHANNELS; c++) begin
                    state_reg[c] <= state_next[c];
                end
            end
            // setup write reloads the LFSR from the seed field
            if (cfg_hit) begin
                setup_reg[cfg_index[CH_IDX_W-1:0]] <= setup_t'(cfg_data);
                state_reg[cfg_index[CH_IDX_W-1:0]].lfsr <= cfg_data[CFG_W-1 -: 12];
            end
        end
    end

    // Payload pipeline
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cyc_reg  <= s_tdata[31:0];
            in_link_reg <= s_tdata[32];
            in_nev_reg  <= s_tdata[64:33];
        end
        if (adv_a) begin
            mid_cyc_reg <= in_cyc_reg;
            mid_nev_reg <= in_nev_reg;
            mid_run_reg <= clk_run;
            for (int c = 0; c < CHANNELS; c++) begin
                mid_down_reg[c]   <= state_next[c].down;
                mid_level_reg[c]  <= state_next[c].level;
                mid_status_reg[c] <= state_next[c].status;
            end
        end
        if (adv_b) begin
            out_data_reg <= out_data_next;
        end
    end

    // Predicted underflow cycles and their minimum with the incoming event
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            pred_div[c] = 4'd4 + {1'b0, setup_reg[c].prescale};
            pred[c]     = mid_down_reg[c][31] ? 32'd1
                                              : ((mid_down_reg[c] + 32'd1) << pred_div[c]);
            cand[c]     = pred[c] + mid_cyc_reg;
        end
        nev_min = mid_nev_reg;
        for (int c = 0; c < CHANNELS; c++) begin
            if (mid_run_reg[c] && (cand[c] < nev_min)) begin
                nev_min = cand[c];
            end
        end
        out_data_next = '0;
        for (int c = 0; c < CHANNELS && c < NCH_OUT; c++) begin
            out_data_next[c*SAMPLE_W +: SAMPLE_W]          = mid_level_reg[c];
            out_data_next[FLAGS_LSB + c*FLAGS_W +: FLAGS_W] = mid_status_reg[c];
        end
        out_data_next[NEV_LSB +: 32] = nev_min;
    end

    // Checks on channel state
    for (genvar c = 0; c < CHANNELS; c++) begin : g_chk
        logic [2:0] st;
        assign st = state_reg[c].status;
        `FCLAT_ASSERT(a_down_no_sign, !state_reg[c].down[31], "down counter went negative")
        `FCLAT_ASSERT(a_bout_bin, !st[ST_BORROW_OUT] || st[ST_BORROW_IN], "borrow out alone")
        `FCLAT_ASSERT_NEXT(a_done_sticky, st[ST_DONE], st[ST_DONE], "done flag cleared")
    end

endmodule
`default_nettype wire
